// ----- rtl/ksc_pkg.sv -----
// shared constants, opcodes and control structs for the keyword substitution cipher
// depends on nothing; used by every other file of the block
package ksc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int CHAR_W        = 8;
  localparam int OP_W          = 3;

  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_KEYBYTE = 3'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENCRYPT = 3'd3;
  localparam logic [OP_W-1:0] OP_DECRYPT = 3'd4;

  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHABET_SIZE - 1);

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                clear;
    logic                append;
    logic [LETTER_W-1:0] letter;
  } cell_cmd_t;

  // status returned from the row
  typedef struct packed {
    logic                full;
    logic                found;
    logic [LETTER_W-1:0] found_idx;
    logic                sel_valid;
    logic [LETTER_W-1:0] sel_entry;
  } row_stat_t;

endpackage

// ----- rtl/ksc_in_if.sv -----
// input channel of the cipher: opcode and character word with valid/ready
// depends on ksc_pkg
interface ksc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ksc_pkg::OP_W-1:0]     opcode;
  logic [ksc_pkg::CHAR_W-1:0]   in_char;

  modport source (output valid, output opcode, output in_char, input ready);
  modport sink   (input valid, input opcode, input in_char, output ready);
endinterface

// ----- rtl/ksc_out_if.sv -----
// result channel of the cipher: character word with valid/ready
// depends on ksc_pkg
interface ksc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ksc_pkg::CHAR_W-1:0]   out_char;

  modport source (output valid, output out_char, input ready);
  modport sink   (input valid, input out_char, output ready);
endinterface

// ----- rtl/ksc_cell.sv -----
// one table entry of the substitution alphabet with its valid flag
// takes the valid flag of its left neighbour; depends on ksc_pkg
module ksc_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ksc_pkg::LETTER_W-1:0]   cell_idx,
  input  ksc_pkg::cell_cmd_t             cmd,
  input  logic                           prev_valid,
  output logic                           valid,
  output logic [ksc_pkg::LETTER_W-1:0]   entry,
  output logic                           match
);

  logic                         valid_r, valid_nxt;
  logic [ksc_pkg::LETTER_W-1:0] entry_r, entry_nxt;

  // clear empties the cell; else the first empty cell after a filled one takes the appended letter
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (cmd.clear) begin
      valid_nxt = 1'b0;
    end else if (cmd.append && prev_valid && !valid_r) begin
      valid_nxt = 1'b1;
      entry_nxt = cmd.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b1;
      entry_r <= cell_idx;
    end else begin
      valid_r <= valid_nxt;
      entry_r <= entry_nxt;
    end
  end

  assign valid = valid_r;
  assign entry = entry_r;
  assign match = valid_r && (entry_r == cmd.letter);

endmodule

// ----- rtl/ksc_cell_row.sv -----
// row of 26 table cells chained by their valid flags, with lookup logic
// depends on ksc_pkg and ksc_cell
module ksc_cell_row (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ksc_pkg::cell_cmd_t             cmd,
  input  logic [ksc_pkg::LETTER_W-1:0]   sel_pos,
  output ksc_pkg::row_stat_t             stat
);

  logic [ksc_pkg::ALPHABET_SIZE-1:0] valid;
  logic [ksc_pkg::ALPHABET_SIZE-1:0] match;
  logic [ksc_pkg::ALPHABET_SIZE-1:0] chain_in;
  logic [ksc_pkg::LETTER_W-1:0]      entry [ksc_pkg::ALPHABET_SIZE];

  assign chain_in = {valid[ksc_pkg::ALPHABET_SIZE-2:0], 1'b1};

  for (genvar i = 0; i < ksc_pkg::ALPHABET_SIZE; i++) begin : g_cell
    ksc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (ksc_pkg::LETTER_W'(i)),
      .cmd        (cmd),
      .prev_valid (chain_in[i]),
      .valid      (valid[i]),
      .entry      (entry[i]),
      .match      (match[i])
    );
  end

  // valid entries are distinct, so at most one cell matches
  always_comb begin
    stat           = '0;
    stat.full      = valid[ksc_pkg::ALPHABET_SIZE-1];
    stat.found     = |match;
    for (int i = 0; i < ksc_pkg::ALPHABET_SIZE; i++) begin
      if (match[i]) begin
        stat.found_idx = stat.found_idx | ksc_pkg::LETTER_W'(i);
      end
      if (sel_pos == ksc_pkg::LETTER_W'(i)) begin
        stat.sel_valid = valid[i];
        stat.sel_entry = entry[i];
      end
    end
  end

endmodule

// ----- rtl/keyword_substitution_cipher.sv -----
// keyword substitution cipher top level: sequencer, used-letter map and output register
// encrypt/decrypt: S_EXEC waits for a free output register, then registers the result
// input is taken only in S_IDLE, one word at a time; finish holds off input while
// the letter counter walks A to Z through the cell row, one letter a cycle
// reset (synchronous, active low): identity table, all letters used, no result pending
module keyword_substitution_cipher (
  input  logic       clk,
  input  logic       rst_n,
  ksc_in_if.sink     in_ch,
  ksc_out_if.source  out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FILL} state_t;

  state_t                              state_r, state_nxt;
  logic [ksc_pkg::OP_W-1:0]            op_r, op_nxt;
  logic [ksc_pkg::CHAR_W-1:0]          char_r, char_nxt;
  logic [ksc_pkg::ALPHABET_SIZE-1:0]   used_r, used_nxt;
  logic [ksc_pkg::LETTER_W-1:0]        fill_letter_r, fill_letter_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [ksc_pkg::CHAR_W-1:0]          out_char_r, out_char_nxt;

  ksc_pkg::cell_cmd_t                  cmd;
  ksc_pkg::row_stat_t                  stat;

  logic                                is_upper, is_lower, is_letter;
  logic [ksc_pkg::CHAR_W-1:0]          pos_wide;
  logic [ksc_pkg::LETTER_W-1:0]        pos;

  ksc_cell_row u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sel_pos (pos),
    .stat    (stat)
  );

  // letter decode of the held word
  always_comb begin
    is_upper  = (char_r >= ksc_pkg::CH_UPPER_A) && (char_r <= ksc_pkg::CH_UPPER_Z);
    is_lower  = (char_r >= ksc_pkg::CH_LOWER_A) && (char_r <= ksc_pkg::CH_LOWER_Z);
    is_letter = is_upper || is_lower;
    pos_wide  = is_lower ? (char_r - ksc_pkg::CH_LOWER_A) : (char_r - ksc_pkg::CH_UPPER_A);
    pos       = pos_wide[ksc_pkg::LETTER_W-1:0];
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    char_nxt        = char_r;
    used_nxt        = used_r;
    fill_letter_nxt = fill_letter_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_char_nxt    = out_char_r;
    cmd             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.opcode;
          char_nxt  = in_ch.in_char;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.letter = pos;
        priority if (op_r == ksc_pkg::OP_START) begin
          cmd.clear = 1'b1;
          used_nxt  = '0;
          state_nxt = S_IDLE;
        end else if (op_r == ksc_pkg::OP_KEYBYTE) begin
          if (is_letter && !used_r[pos] && !stat.full) begin
            cmd.append    = 1'b1;
            used_nxt[pos] = 1'b1;
          end
          state_nxt = S_IDLE;
        end else if (op_r == ksc_pkg::OP_FINISH) begin
          fill_letter_nxt = '0;
          state_nxt       = S_FILL;
        end else if (op_r == ksc_pkg::OP_ENCRYPT || op_r == ksc_pkg::OP_DECRYPT) begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (!is_letter) begin
              out_char_nxt = char_r;
            end else if (op_r == ksc_pkg::OP_ENCRYPT) begin
              out_char_nxt = stat.sel_valid
                ? ksc_pkg::CH_UPPER_A + ksc_pkg::CHAR_W'(stat.sel_entry)
                : ksc_pkg::CH_UPPER_A + ksc_pkg::CHAR_W'(pos);
            end else if (stat.found) begin
              out_char_nxt = (is_lower ? ksc_pkg::CH_LOWER_A : ksc_pkg::CH_UPPER_A)
                             + ksc_pkg::CHAR_W'(stat.found_idx);
            end else begin
              out_char_nxt = char_r;
            end
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.letter = fill_letter_r;
        if (!used_r[fill_letter_r] && !stat.full) begin
          cmd.append              = 1'b1;
          used_nxt[fill_letter_r] = 1'b1;
        end
        fill_letter_nxt = fill_letter_r + 1'b1;
        if (fill_letter_r == ksc_pkg::LAST_LETTER) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      used_r        <= '1;
      fill_letter_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      used_r        <= used_nxt;
      fill_letter_r <= fill_letter_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    char_r     <= char_nxt;
    out_char_r <= out_char_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;

endmodule

// ----- tb/cipher_tracker_pkg.sv -----
`timescale 1ns / 100ps
// scoreboard class for the keyword substitution cipher testbench: keeps its own
// substitution alphabet, predicts each result character and checks it on arrival
// depends on ksc_pkg
package cipher_tracker_pkg;

  import ksc_pkg::*;

  class cipher_tracker;
    logic [LETTER_W-1:0]      key_alphabet [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] letters_used;
    int unsigned              fill_count;
    logic [CHAR_W-1:0]        pending_chars [$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              finishes;
    int unsigned              partial_lookups;

    function new();
      for (int i = 0; i < ALPHABET_SIZE; i++) key_alphabet[i] = LETTER_W'(i);
      letters_used    = '1;
      fill_count      = ALPHABET_SIZE;
      errors          = 0;
      checked         = 0;
      finishes        = 0;
      partial_lookups = 0;
    endfunction

    // letter position 0..25, or -1 for anything else
    static function int letter_index(logic [CHAR_W-1:0] ch, output bit lower);
      lower = 1'b0;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return int'(ch - CH_UPPER_A);
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
        lower = 1'b1;
        return int'(ch - CH_LOWER_A);
      end
      return -1;
    endfunction

    function void append_letter(int idx);
      if (fill_count >= ALPHABET_SIZE || letters_used[idx]) return;
      key_alphabet[fill_count] = LETTER_W'(idx);
      fill_count++;
      letters_used[idx] = 1'b1;
    endfunction

    // called for every accepted input word
    function void accept_word(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
      int                pos;
      bit                lower;
      logic [CHAR_W-1:0] result;
      pos    = letter_index(ch, lower);
      result = ch;
      case (op)
        OP_START: begin
          letters_used = '0;
          fill_count   = 0;
        end
        OP_KEYBYTE: begin
          if (pos >= 0) append_letter(pos);
        end
        OP_FINISH: begin
          for (int i = 0; i < ALPHABET_SIZE; i++) append_letter(i);
          finishes++;
        end
        OP_ENCRYPT, OP_DECRYPT: begin
          if (fill_count < ALPHABET_SIZE) partial_lookups++;
          if (pos >= 0 && op == OP_ENCRYPT) begin
            if (pos < fill_count) result = CH_UPPER_A + key_alphabet[pos];
            else result = CH_UPPER_A + CHAR_W'(pos);
          end else if (pos >= 0) begin
            for (int i = 0; i < fill_count; i++) begin
              if (key_alphabet[i] == LETTER_W'(pos)) begin
                result = (lower ? CH_LOWER_A : CH_UPPER_A) + CHAR_W'(i);
                break;
              end
            end
          end
          pending_chars.push_back(result);
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [CHAR_W-1:0] got, logic [CHAR_W-1:0] want);
      $display("cipher mismatch: %s: got %02h, expected %02h", what, got, want);
      errors++;
    endtask

    // called for every accepted result word
    task check_char(logic [CHAR_W-1:0] got);
      logic [CHAR_W-1:0] want;
      if (pending_chars.size() == 0) begin
        report("result word with nothing pending", got, '0);
        return;
      end
      want = pending_chars.pop_front();
      checked++;
      if (got !== want) report("out_char", got, want);
    endtask
  endclass

endpackage

// ----- tb/tb_keyword_substitution_cipher.sv -----
`timescale 1ns / 100ps
// top testbench of the keyword substitution cipher: drives start, keyword, finish and
// character words with random idling on both sides and checks every result word
// depends on ksc_pkg, the two channel interfaces, cipher_tracker_pkg and the rtl
module tb_keyword_substitution_cipher;

  import ksc_pkg::*;
  import cipher_tracker_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned STALL_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned WORD_TARGET   = 950;
  localparam int unsigned OP_ANY_MAX    = (1 << OP_W) - 1;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_DECRYPT + 1'b1;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = '1;
  localparam logic [CHAR_W-1:0] CASE_STEP    = CH_LOWER_A - CH_UPPER_A;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned words_sent = 0;
  int unsigned stall_requests = 0;
  int unsigned cycle_count = 0;

  cipher_tracker tracker = new();

  ksc_in_if  in_ch();
  ksc_out_if out_ch();

  keyword_substitution_cipher i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_keyword_substitution_cipher: done, errors");
      $finish;
    end
  end

  // result side: random ready, plus long hold-offs on request
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned stalls_served;
    stall_left    = 0;
    stalls_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) tracker.check_char(out_ch.out_char);
      if (stalls_served != stall_requests) begin
        stalls_served = stall_requests;
        stall_left    = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [CHAR_W-1:0] random_case(logic [CHAR_W-1:0] upper);
    return $urandom_range(1) ? upper + CASE_STEP : upper;
  endfunction

  function automatic logic [CHAR_W-1:0] any_letter();
    return random_case(CH_UPPER_A + CHAR_W'($urandom_range(ALPHABET_SIZE - 1)));
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.in_char <= ch;
    do @(posedge clk); while (!in_ch.ready);
    tracker.accept_word(op, ch);
    if (op <= OP_DECRYPT) words_sent++;
  endtask

  task automatic send_directed();
    // identity table after reset, letter boundaries, high bytes and spare opcodes
    send_word(OP_ENCRYPT, "A");
    send_word(OP_ENCRYPT, "z");
    send_word(OP_ENCRYPT, CH_UPPER_A - 1'b1);
    send_word(OP_ENCRYPT, CH_UPPER_Z + 1'b1);
    send_word(OP_DECRYPT, CH_LOWER_A - 1'b1);
    send_word(OP_DECRYPT, CH_LOWER_Z + 1'b1);
    send_word(OP_ENCRYPT, 8'h00);
    send_word(OP_DECRYPT, 8'hFF);
    send_word(OP_ENCRYPT, 8'h80);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) send_word(OP_W'(op), "A");
    // partial keyword with a non-letter and a repeat
    send_word(OP_START, "x");
    send_word(OP_KEYBYTE, "K");
    send_word(OP_KEYBYTE, "e");
    send_word(OP_KEYBYTE, "!");
    send_word(OP_KEYBYTE, "k");
    send_word(OP_KEYBYTE, 8'hC5);
    send_word(OP_ENCRYPT, "b");
    send_word(OP_ENCRYPT, "z");
    send_word(OP_DECRYPT, "k");
    send_word(OP_DECRYPT, "Q");
    // finish, then keyword byte and finish on a full table
    send_word(OP_FINISH, "x");
    send_word(OP_KEYBYTE, "q");
    send_word(OP_FINISH, "x");
    send_word(OP_DECRYPT, "e");
  endtask

  task automatic send_round();
    int unsigned kind;
    int unsigned offset;
    int unsigned count;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_word(OP_W'($urandom_range(OP_ANY_MAX)), CHAR_W'($urandom));
      return;
    end
    send_word(OP_START, CHAR_W'($urandom));
    if (kind < 16) begin
      // whole alphabet from a random letter, wrapping, then two more on a full table
      offset = $urandom_range(ALPHABET_SIZE - 1);
      for (int i = 0; i < ALPHABET_SIZE + 2; i++)
        send_word(OP_KEYBYTE,
                  random_case(CH_UPPER_A + CHAR_W'((offset + i) % ALPHABET_SIZE)));
    end else begin
      count = $urandom_range(10);
      repeat (count)
        send_word(OP_KEYBYTE, ($urandom_range(6) == 0) ? CHAR_W'($urandom) : any_letter());
    end
    if ($urandom_range(9) != 0) send_word(OP_FINISH, CHAR_W'($urandom));
    count = $urandom_range(14, 1);
    repeat (count) begin
      if ($urandom_range(15) == 0) send_word(OP_KEYBYTE, any_letter());
      else send_word($urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT,
                     ($urandom_range(4) == 0) ? CHAR_W'($urandom) : any_letter());
    end
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_START;
    in_ch.in_char <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 21;
    rx_idle_pct = 66;
    send_directed();
    stall_requests <= stall_requests + 1;
    while (words_sent < WORD_TARGET / 3) send_round();

    tx_idle_pct = 66;
    rx_idle_pct = 21;
    while (words_sent < 2 * WORD_TARGET / 3) send_round();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    stall_requests <= stall_requests + 1;
    while (words_sent < WORD_TARGET) send_round();
    in_ch.valid <= 1'b0;

    while (tracker.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run summary: %0d words sent, %0d result words checked, %0d finish words",
             words_sent, tracker.checked, tracker.finishes);
    $display("run summary: %0d lookups on partly built tables, %0d mismatches",
             tracker.partial_lookups, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_keyword_substitution_cipher: done, clean");
    end else begin
      $display("tb_keyword_substitution_cipher: done, errors");
    end
    $finish;
  end

endmodule
